@@ rtl/pli_pkg.sv @@
// Shared types and constants for the piecewise-linear table interpolator.
package pli_pkg;

  localparam int unsigned MAX_POINTS_DEF = 64;
  localparam int unsigned COUNT_W        = 7;
  localparam int unsigned INDEX_W        = 6;
  localparam int unsigned DATA_W         = 32;
  localparam int unsigned DIV_STEPS      = 32;
  localparam logic [COUNT_W-1:0] COUNT_RST = 7'd2;

  // opcode codes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // status codes
  localparam logic ST_GOOD  = 1'b0;
  localparam logic ST_RANGE = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic wr_en;
    logic cap_query;
    logic cap_first;
    logic cap_last;
    logic step_prev;
    logic cap_cur;
    logic prep;
    logic mul;
    logic div_step;
    logic add;
    logic fix;
    logic set_oor;
    logic set_first;
    logic set_last;
    logic out_load;
  } pli_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic oor;
    logic eq_first;
    logic eq_last;
    logic cur_lt;
  } pli_sts_t;

endpackage

@@ rtl/pli_if.sv @@
// Valid/ready channel interfaces for input items and result items.
interface pli_in_if;
  import pli_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     opcode;
  logic [INDEX_W-1:0]       entry_index;
  logic signed [DATA_W-1:0] entry_x;
  logic signed [DATA_W-1:0] entry_y;
  logic signed [DATA_W-1:0] query_x;

  modport source (output valid, output opcode, output entry_index, output entry_x,
                  output entry_y, output query_x, input ready);
  modport sink   (input valid, input opcode, input entry_index, input entry_x,
                  input entry_y, input query_x, output ready);
endinterface

interface pli_out_if;
  import pli_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] out_y;
  logic                     status;

  modport source (output valid, output out_y, output status, input ready);
  modport sink   (input valid, input out_y, input status, output ready);
endinterface

@@ rtl/pli_dp.sv @@
// Datapath: breakpoint memory, bounds compare, multiplier, serial divider, output regs.
module pli_dp #(
  parameter int unsigned MAX_POINTS = pli_pkg::MAX_POINTS_DEF
) (
  input  logic                              clk_i,
  input  pli_pkg::pli_cmd_t                 cmd_i,
  input  logic [$clog2(MAX_POINTS)-1:0]     rd_addr_i,
  input  logic [pli_pkg::INDEX_W-1:0]       entry_index_i,
  input  logic signed [pli_pkg::DATA_W-1:0] entry_x_i,
  input  logic signed [pli_pkg::DATA_W-1:0] entry_y_i,
  input  logic signed [pli_pkg::DATA_W-1:0] query_x_i,
  output pli_pkg::pli_sts_t                 sts_o,
  output logic signed [pli_pkg::DATA_W-1:0] out_y_o,
  output logic                              status_o
);
  import pli_pkg::*;

  localparam int unsigned AW = $clog2(MAX_POINTS);
  localparam int unsigned DW = DATA_W;

  logic [2*DW-1:0] mem_q [MAX_POINTS];
  logic [2*DW-1:0] rd_data_q;

  logic [31:0]    idx_ext;
  logic           wr_ok;
  logic [AW-1:0]  waddr;

  logic signed [DW-1:0] rd_x, rd_y;
  logic signed [DW-1:0] x_q, first_x_q, first_y_q, last_x_q, last_y_q;
  logic signed [DW-1:0] xa_q, ya_q, xb_q, yb_q;
  logic [DW-1:0]        d_q, t_q, m_q;
  logic                 neg_q;
  logic [DW-1:0]        rem_q, quo_q;
  logic signed [DW+1:0] v_q;
  logic signed [DW-1:0] res_y_q, out_y_q;
  logic                 res_st_q, out_st_q;

  logic signed [DW:0]   d_diff, t_diff, dy_diff;
  logic [DW:0]          dy_mag;
  logic [2*DW-1:0]      prod;
  logic [DW:0]          shifted;
  logic [DW+1:0]        sub;
  logic                 ge;
  logic signed [DW+1:0] v_add, v_fix;
  logic signed [DW-1:0] v_sat;

  assign idx_ext = 32'(entry_index_i);
  assign wr_ok   = idx_ext < MAX_POINTS;
  assign waddr   = idx_ext[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en && wr_ok) begin
      mem_q[waddr] <= {entry_x_i, entry_y_i};
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_x = rd_data_q[2*DW-1:DW];
  assign rd_y = rd_data_q[DW-1:0];

  assign sts_o.oor      = (x_q < first_x_q) || (x_q > last_x_q);
  assign sts_o.eq_first = (x_q == first_x_q);
  assign sts_o.eq_last  = (x_q == last_x_q);
  assign sts_o.cur_lt   = (rd_x < x_q);

  // segment differences; divisor and offset are positive by construction
  always_comb begin
    d_diff  = {xb_q[DW-1], xb_q} - {xa_q[DW-1], xa_q};
    t_diff  = {x_q[DW-1], x_q} - {xa_q[DW-1], xa_q};
    dy_diff = {yb_q[DW-1], yb_q} - {ya_q[DW-1], ya_q};
    dy_mag  = dy_diff[DW] ? (DW+1)'(-dy_diff) : dy_diff;
  end

  assign prod = {{DW{1'b0}}, t_q} * {{DW{1'b0}}, m_q};

  // restoring divide step: remainder stays below the divisor
  always_comb begin
    shifted = {rem_q, quo_q[DW-1]};
    sub     = {1'b0, shifted} - {2'b00, d_q};
    ge      = !sub[DW+1];
  end

  always_comb begin
    v_add = neg_q ? ({{2{ya_q[DW-1]}}, ya_q} - {2'b00, quo_q})
                  : ({{2{ya_q[DW-1]}}, ya_q} + {2'b00, quo_q});
    // truncate toward zero where the exact value crosses zero
    v_fix = v_q;
    if (rem_q != '0) begin
      if (!neg_q && v_q < 0) begin
        v_fix = v_q + 1;
      end else if (neg_q && v_q > 0) begin
        v_fix = v_q - 1;
      end
    end
    if (v_fix[DW+1:DW-1] == 3'b000 || v_fix[DW+1:DW-1] == 3'b111) begin
      v_sat = v_fix[DW-1:0];
    end else if (v_fix[DW+1]) begin
      v_sat = {1'b1, {(DW-1){1'b0}}};
    end else begin
      v_sat = {1'b0, {(DW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_query) begin
      x_q <= query_x_i;
    end
    if (cmd_i.cap_first) begin
      first_x_q <= rd_x;
      first_y_q <= rd_y;
      xa_q      <= rd_x;
      ya_q      <= rd_y;
    end
    if (cmd_i.cap_last) begin
      last_x_q <= rd_x;
      last_y_q <= rd_y;
    end
    if (cmd_i.step_prev) begin
      xa_q <= rd_x;
      ya_q <= rd_y;
    end
    if (cmd_i.cap_cur) begin
      xb_q <= rd_x;
      yb_q <= rd_y;
    end
    if (cmd_i.prep) begin
      d_q   <= d_diff[DW-1:0];
      t_q   <= t_diff[DW-1:0];
      m_q   <= dy_mag[DW-1:0];
      neg_q <= dy_diff[DW];
    end
    if (cmd_i.mul) begin
      rem_q <= prod[2*DW-1:DW];
      quo_q <= prod[DW-1:0];
    end
    if (cmd_i.div_step) begin
      rem_q <= ge ? sub[DW-1:0] : shifted[DW-1:0];
      quo_q <= {quo_q[DW-2:0], ge};
    end
    if (cmd_i.add) begin
      v_q <= v_add;
    end
    if (cmd_i.fix) begin
      res_y_q  <= v_sat;
      res_st_q <= ST_GOOD;
    end
    if (cmd_i.set_oor) begin
      res_y_q  <= '0;
      res_st_q <= ST_RANGE;
    end
    if (cmd_i.set_first) begin
      res_y_q  <= first_y_q;
      res_st_q <= ST_GOOD;
    end
    if (cmd_i.set_last) begin
      res_y_q  <= last_y_q;
      res_st_q <= ST_GOOD;
    end
    if (cmd_i.out_load) begin
      out_y_q  <= res_y_q;
      out_st_q <= res_st_q;
    end
  end

  assign out_y_o  = out_y_q;
  assign status_o = out_st_q;

endmodule

@@ rtl/pli_ctrl.sv @@
// Controller: query sequencer, point count register and output valid.
module pli_ctrl #(
  parameter int unsigned MAX_POINTS = pli_pkg::MAX_POINTS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pli_pkg::COUNT_W-1:0]   cfg_wdata_i,
  input  logic                          in_valid_i,
  input  logic                          in_opcode_i,
  output logic                          in_ready_o,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  input  pli_pkg::pli_sts_t             sts_i,
  output pli_pkg::pli_cmd_t             cmd_o,
  output logic [$clog2(MAX_POINTS)-1:0] rd_addr_o
);
  import pli_pkg::*;

  localparam int unsigned AW  = $clog2(MAX_POINTS);
  localparam int unsigned DCW = $clog2(DIV_STEPS);

  typedef enum logic [3:0] {
    S_IDLE, S_RD_FIRST, S_RD_LAST, S_CHECK, S_SEARCH,
    S_PREP, S_MUL, S_DIV, S_ADD, S_FIX, S_OUT
  } state_e;

  state_e             state_q, state_d;
  logic [AW-1:0]      i_q, i_d;
  logic [DCW-1:0]     div_cnt_q, div_cnt_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic               out_valid_q, out_valid_d;

  logic [31:0]   cnt_ext, last_full;
  logic [AW-1:0] last_idx;

  // point count clamped to [2, MAX_POINTS], as the last index in use
  always_comb begin
    cnt_ext = 32'(count_q);
    if (cnt_ext < 32'd2) begin
      last_full = 32'd1;
    end else if (cnt_ext > MAX_POINTS) begin
      last_full = 32'(MAX_POINTS - 1);
    end else begin
      last_full = cnt_ext - 32'd1;
    end
    last_idx = last_full[AW-1:0];
  end

  always_comb begin
    state_d     = state_q;
    i_d         = i_q;
    div_cnt_d   = div_cnt_q;
    count_d     = cfg_we_i ? cfg_wdata_i : count_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    rd_addr_o   = i_q;
    in_ready_o  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        rd_addr_o  = '0;
        if (in_valid_i) begin
          if (in_opcode_i == OP_QUERY) begin
            cmd_o.cap_query = 1'b1;
            state_d         = S_RD_FIRST;
          end else begin
            cmd_o.wr_en = 1'b1;
          end
        end
      end
      S_RD_FIRST: begin
        cmd_o.cap_first = 1'b1;
        rd_addr_o       = last_idx;
        state_d         = S_RD_LAST;
      end
      S_RD_LAST: begin
        cmd_o.cap_last = 1'b1;
        rd_addr_o      = AW'(1);
        i_d            = AW'(1);
        state_d        = S_CHECK;
      end
      S_CHECK: begin
        if (sts_i.oor) begin
          cmd_o.set_oor = 1'b1;
          state_d       = S_OUT;
        end else if (sts_i.eq_first) begin
          cmd_o.set_first = 1'b1;
          state_d         = S_OUT;
        end else if (sts_i.eq_last) begin
          cmd_o.set_last = 1'b1;
          state_d        = S_OUT;
        end else begin
          state_d = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (i_q < last_idx && sts_i.cur_lt) begin
          cmd_o.step_prev = 1'b1;
          i_d             = i_q + AW'(1);
          rd_addr_o       = i_q + AW'(1);
        end else begin
          cmd_o.cap_cur = 1'b1;
          state_d       = S_PREP;
        end
      end
      S_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        div_cnt_d = '0;
        state_d   = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        div_cnt_d      = div_cnt_q + DCW'(1);
        if (div_cnt_q == DCW'(DIV_STEPS - 1)) begin
          state_d = S_ADD;
        end
      end
      S_ADD: begin
        cmd_o.add = 1'b1;
        state_d   = S_FIX;
      end
      S_FIX: begin
        cmd_o.fix = 1'b1;
        state_d   = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      i_q         <= '0;
      div_cnt_q   <= '0;
      count_q     <= COUNT_RST;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      i_q         <= i_d;
      div_cnt_q   <= div_cnt_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ rtl/piecewise_linear_table_interp.sv @@
// Piecewise-linear lookup table: load and query sequencer around a breakpoint memory.
// Sequence: a load is written at its transfer. A query reads the first and last entries, then
//   sets its result if outside the table or on an end point; an interior one scans entries
//   k = 1..n-1 one per cycle, multiplies, runs the restoring divider; an untaken result stalls.
// Throughput: one query in flight; the next transfer is taken once its result is loaded.
// Reset (async, active low): idle, result valid cleared, point_count 2, memory not cleared.
module piecewise_linear_table_interp #(
  parameter int unsigned MAX_POINTS = pli_pkg::MAX_POINTS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [pli_pkg::COUNT_W-1:0] cfg_wdata_i,
  pli_in_if.sink                      in_i,
  pli_out_if.source                   out_o
);
  import pli_pkg::*;

  localparam int unsigned AW = $clog2(MAX_POINTS);

  pli_cmd_t      cmd;
  pli_sts_t      sts;
  logic [AW-1:0] rd_addr;
  logic          in_ready;
  logic          out_valid;

  // sequencer: owns point_count, walks the table, paces the divider
  pli_ctrl #(
    .MAX_POINTS (MAX_POINTS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_i.valid),
    .in_opcode_i (in_i.opcode),
    .in_ready_o  (in_ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_valid),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .rd_addr_o   (rd_addr)
  );

  // datapath: memory, compares, multiply, divide, result register
  pli_dp #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dp (
    .clk_i         (clk_i),
    .cmd_i         (cmd),
    .rd_addr_i     (rd_addr),
    .entry_index_i (in_i.entry_index),
    .entry_x_i     (in_i.entry_x),
    .entry_y_i     (in_i.entry_y),
    .query_x_i     (in_i.query_x),
    .sts_o         (sts),
    .out_y_o       (out_o.out_y),
    .status_o      (out_o.status)
  );

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;

endmodule

@@ verif/piecewise_linear_table_interp_tb.sv @@
// Self-checking testbench for the piecewise-linear breakpoint table interpolator.
module piecewise_linear_table_interp_tb;
  import pli_pkg::*;

  localparam int unsigned     MAX_PTS       = MAX_POINTS_DEF;
  localparam int unsigned     RANDOM_ITEMS  = 2000;
  // Settle time after the owed results; longer than the longest query.
  localparam int unsigned     SETTLE_CYCLES = 120;
  localparam longint unsigned CYCLE_LIMIT   = 3_000_000;

  localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] Q_ONE = 32'sh0001_0000;

  typedef struct packed {
    logic signed [DATA_W-1:0] y;
    logic                     status;
  } interp_result_t;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [COUNT_W-1:0] cfg_wdata;

  pli_in_if  in_if ();
  pli_out_if out_if ();

  piecewise_linear_table_interp dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  // Shadow copy of the breakpoint table and the count register.
  logic signed [DATA_W-1:0] bp_x [MAX_PTS];
  logic signed [DATA_W-1:0] bp_y [MAX_PTS];
  logic [COUNT_W-1:0]       bp_count;

  // Interpolation results still owed by the block, oldest first.
  interp_result_t pending_interp_q [$];
  interp_result_t oldest_r;

  bit              steady;  // when set, neither side inserts gaps
  int              fail_cnt;
  int              load_cnt;
  int              query_cnt;
  int              oor_cnt;
  int              checked_cnt;
  int              setting_cnt;
  longint unsigned cycle_cnt;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor helpers
  // ---------------------------------------------------------------------------

  // Count register is clamped to [2, MAX_PTS] before use.
  function automatic int unsigned points_in_use();
    if (bp_count < 2) return 2;
    if (bp_count > MAX_PTS) return MAX_PTS;
    return 32'(bp_count);
  endfunction

  function automatic logic signed [DATA_W-1:0] sat32(longint v);
    if (v > longint'(Q_MAX)) return Q_MAX;
    if (v < longint'(Q_MIN)) return Q_MIN;
    return v[DATA_W-1:0];
  endfunction

  // Uniform-ish pick in [lo, hi]; spans here never exceed 2^32.
  function automatic longint rand_span(longint lo, longint hi);
    if (hi <= lo) return lo;
    return lo + (longint'($urandom) % (hi - lo + 1));
  endfunction

  // Expected result of one query against the shadow table.
  function automatic interp_result_t interp_predict(logic signed [DATA_W-1:0] qx);
    interp_result_t      res;
    int unsigned         n;
    int unsigned         i;
    logic signed [127:0] xa, xb, ya, yb, xq, num, quo;
    n          = points_in_use();
    res.y      = '0;
    res.status = ST_GOOD;
    if (qx < bp_x[0] || qx > bp_x[n-1]) begin
      res.status = ST_RANGE;
    end else if (qx == bp_x[0]) begin
      res.y = bp_y[0];
    end else if (qx == bp_x[n-1]) begin
      res.y = bp_y[n-1];
    end else begin
      // First breakpoint from index 1 at or above the query; the one below
      // is then strictly under it, even for a table that is not ascending.
      i = 1;
      while (i < n - 1 && bp_x[i] < qx) i++;
      xa  = bp_x[i-1];
      ya  = bp_y[i-1];
      xb  = bp_x[i];
      yb  = bp_y[i];
      xq  = qx;
      // Exact Q32.32 numerator, one division truncating toward zero.
      num = ya * (xb - xa) + (xq - xa) * (yb - ya);
      quo = num / (xb - xa);
      if (quo > 128'sd2147483647) res.y = Q_MAX;
      else if (quo < -128'sd2147483648) res.y = Q_MIN;
      else res.y = quo[DATA_W-1:0];
    end
    return res;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 60);
  endfunction

  // Query abscissa aimed at the interesting spots of the current table.
  function automatic logic signed [DATA_W-1:0] pick_query_x();
    int unsigned n, k, r;
    longint      lo, hi, first, last;
    n     = points_in_use();
    first = bp_x[0];
    last  = bp_x[n-1];
    r     = $urandom_range(0, 99);
    if (r < 30) begin
      k  = $urandom_range(1, n - 1);
      lo = bp_x[k-1];
      hi = bp_x[k];
      return sat32(hi > lo ? rand_span(lo + 1, hi) : hi);
    end
    if (r < 45) return bp_x[$urandom_range(0, n - 1)];
    if (r < 55) return $urandom_range(0, 1) ? bp_x[0] : bp_x[n-1];
    if (r < 65) return $urandom_range(0, 1) ? sat32(first - 1) : sat32(last + 1);
    if (r < 80) return sat32(last >= first ? rand_span(first, last) : first);
    return $urandom;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Drives one item at a falling edge, holds it until the transfer, and feeds
  // the predictor at the accepting edge. Valid stays high into the next call
  // unless a gap is drawn.
  task automatic send_item(logic op, logic [INDEX_W-1:0] idx,
                           logic signed [DATA_W-1:0] ex, logic signed [DATA_W-1:0] ey,
                           logic signed [DATA_W-1:0] qx);
    int unsigned    gap;
    interp_result_t res;
    gap = pick_gap();
    @(negedge clk);
    if (gap != 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.opcode      = op;
    in_if.entry_index = idx;
    in_if.entry_x     = ex;
    in_if.entry_y     = ey;
    in_if.query_x     = qx;
    in_if.valid       = 1'b1;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    if (op == OP_LOAD) begin
      bp_x[idx] = ex;
      bp_y[idx] = ey;
      load_cnt++;
    end else begin
      res = interp_predict(qx);
      pending_interp_q.push_back(res);
      query_cnt++;
      if (res.status == ST_RANGE) oor_cnt++;
    end
  endtask

  // Unused fields of each kind carry random noise.
  task automatic send_load(logic [INDEX_W-1:0] idx, logic signed [DATA_W-1:0] px,
                           logic signed [DATA_W-1:0] py);
    send_item(OP_LOAD, idx, px, py, $urandom);
  endtask

  task automatic send_query(logic signed [DATA_W-1:0] qx);
    send_item(OP_QUERY, INDEX_W'($urandom_range(0, MAX_PTS - 1)), $urandom, $urandom, qx);
  endtask

  // Drop valid and wait until every owed result is in, plus the longest
  // latency so that no query is still in the divider.
  task automatic drain();
    @(negedge clk);
    in_if.valid = 1'b0;
    while (pending_interp_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_point_count(logic [COUNT_W-1:0] value);
    drain();
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(posedge clk);
    bp_count = value;
    @(negedge clk);
    cfg_we = 1'b0;
    setting_cnt++;
  endtask

  // Writes entries 0..n-1 with one of several table shapes.
  task automatic load_table(int unsigned n);
    int unsigned              style, k;
    bit                       wide;
    longint                   cur, step_max;
    logic signed [DATA_W-1:0] px, py;
    style = $urandom_range(0, 9);
    wide  = (style >= 4 && style <= 7);
    if (wide) begin
      // Spread across the whole Q16.16 range, large divisors.
      step_max = (longint'(1) << 32) / n;
      cur      = longint'(Q_MIN) + rand_span(0, step_max - 1);
    end else begin
      step_max = rand_span(1, 'h40000);
      cur      = rand_span(-(longint'(1) << 30), longint'(1) << 30);
    end
    for (k = 0; k < n; k++) begin
      // style 9: shuffled abscissas, table not ascending
      px = (style == 9) ? $urandom : sat32(cur);
      if (style == 7) py = $urandom_range(0, 1) ? Q_MAX : Q_MIN;  // steepest slopes
      else if (style[0]) py = $urandom;
      else py = sat32(rand_span(-16 * longint'(Q_ONE), 16 * longint'(Q_ONE)));
      send_load(INDEX_W'(k), px, py);
      // style 8: repeated abscissas now and then
      if (style == 8 && $urandom_range(0, 2) == 0) cur = cur;
      else cur = cur + rand_span(1, step_max);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Count at its reset value of two: both bounds, both end points, interior.
  task automatic test_two_point_bounds();
    send_load(0, -Q_ONE, 3 * Q_ONE);
    send_load(1, 2 * Q_ONE, -3 * Q_ONE);
    send_query(-Q_ONE - 1);
    send_query(-Q_ONE);
    send_query(0);
    send_query(2 * Q_ONE);
    send_query(2 * Q_ONE + 1);
    send_query(Q_MIN);
    send_query(Q_MAX);
  endtask

  // One segment over the full range: divisor 2^32-1, slope -1, step of one LSB.
  task automatic test_full_range_segment();
    send_load(0, Q_MIN, Q_MAX);
    send_load(1, Q_MAX, Q_MIN);
    send_query(Q_MIN);
    send_query(Q_MAX);
    send_query(Q_MIN + 1);
    send_query(Q_MAX - 1);
    send_query(0);
  endtask

  // Three points, then a count of zero which must act as two.
  task automatic test_point_count_clamp();
    send_load(1, 0, 'h100);
    send_load(2, Q_ONE, -'sh100);
    send_load(INDEX_W'(MAX_PTS - 1), 5, 5);
    write_point_count(7'd3);
    send_query(0);      // lands exactly on an interior breakpoint
    send_query(1);
    send_query(Q_ONE);
    send_query(Q_MIN);
    write_point_count(7'd0);
    send_query(0);
    send_query(1);
  endtask

  // Phases of: new count, fresh table, then queries mixed with stray loads.
  // The first six phases walk the count extremes, the rest pick at random.
  task automatic test_random_tables(int unsigned target);
    int unsigned        sent, phase, n, nq, j, r;
    logic [COUNT_W-1:0] cnt;
    sent  = 0;
    phase = 0;
    while (sent < target) begin
      case (phase)
        0: cnt = 7'd0;
        1: cnt = 7'd1;
        2: cnt = 7'd2;
        3: cnt = 7'd64;
        4: cnt = 7'd65;
        5: cnt = 7'd127;
        default: begin
          r = $urandom_range(0, 99);
          if (r < 8) cnt = COUNT_W'($urandom_range(0, 127));
          else if (r < 70) cnt = COUNT_W'($urandom_range(2, 8));
          else cnt = COUNT_W'($urandom_range(2, 64));
        end
      endcase
      write_point_count(cnt);
      steady = ($urandom_range(0, 4) == 0);
      n = points_in_use();
      load_table(n);
      sent += n;
      nq = $urandom_range(8, 40);
      for (j = 0; j < nq; j++) begin
        // Stray loads may land in use and break the ordering; that is legal.
        if ($urandom_range(0, 99) < 12) begin
          send_load(INDEX_W'($urandom_range(0, MAX_PTS - 1)), $urandom, $urandom);
        end else begin
          send_query(pick_query_x());
        end
        if ($urandom_range(0, 99) == 0) drain();
        sent++;
      end
      phase++;
    end
    steady = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  // Result ready: random stalls, none while steady.
  initial begin : result_ready_gen
    int unsigned hold;
    hold         = 0;
    out_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold != 0) begin
        out_if.ready = 1'b0;
        hold--;
      end else begin
        out_if.ready = 1'b1;
        if ($urandom_range(0, 3) == 0) hold = pick_gap();
      end
    end
  end

  // Each result transfer is matched against the oldest owed result.
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_interp_q.size() == 0) begin
        $error("result with nothing owed: out_y %0d status %0d", out_if.out_y, out_if.status);
        fail_cnt++;
      end else begin
        oldest_r = pending_interp_q.pop_front();
        checked_cnt++;
        if (out_if.out_y !== oldest_r.y) begin
          $error("out_y: expected %0d, got %0d", oldest_r.y, out_if.out_y);
          fail_cnt++;
        end
        if (out_if.status !== oldest_r.status) begin
          $error("status: expected %0d, got %0d", oldest_r.status, out_if.status);
          fail_cnt++;
        end
      end
    end
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    in_if.valid       = 1'b0;
    in_if.opcode      = OP_LOAD;
    in_if.entry_index = '0;
    in_if.entry_x     = '0;
    in_if.entry_y     = '0;
    in_if.query_x     = '0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    rst_n             = 1'b0;
    bp_count          = COUNT_RST;
    steady            = 1'b0;
    fail_cnt          = 0;
    load_cnt          = 0;
    query_cnt         = 0;
    oor_cnt           = 0;
    checked_cnt       = 0;
    setting_cnt       = 0;
    cycle_cnt         = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_two_point_bounds();
    test_full_range_segment();
    test_point_count_clamp();
    test_random_tables(RANDOM_ITEMS);
    drain();

    $display("Covered %0d loads and %0d queries (%0d outside the table) over %0d count settings.",
             load_cnt, query_cnt, oor_cnt, setting_cnt);
    $display("Compared %0d results with %0d mismatches in %0d cycles.",
             checked_cnt, fail_cnt, cycle_cnt);
    if (fail_cnt == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/pli_pkg.sv
rtl/pli_if.sv
rtl/pli_dp.sv
rtl/pli_ctrl.sv
rtl/piecewise_linear_table_interp.sv
verif/piecewise_linear_table_interp_tb.sv
